// ----- rtl/sbpq_pkg.sv -----
// Shared types and constants for the sorted byte priority queue.
package sbpq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 8;
	localparam int FILL_W    = 5;
	localparam int STAT_W    = 2;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;  // load the result registers
		logic insert;   // shift the chain open and write the value
		logic pop;      // remove the head entry
	} dp_ctl_t;

	// Datapath to controller.
	typedef struct packed {
		logic empty;
		logic full;
	} dp_stat_t;

endpackage

// ----- rtl/sbpq_datapath.sv -----
// Entry chain, fill count and result registers of the priority queue.
module sbpq_datapath #(
	parameter int DEPTH = sbpq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sbpq_pkg::dp_ctl_t               ctl,
	input  logic [sbpq_pkg::VAL_W-1:0]      value,
	output sbpq_pkg::dp_stat_t              stat,
	output logic [sbpq_pkg::VAL_W-1:0]      popped_value,
	output logic [sbpq_pkg::FILL_W-1:0]     fill_level
);
	import sbpq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [VAL_W-1:0]          ent_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic [CNT_W+FILL_W-1:0]   count_ext;
	logic [DEPTH-1:0]          gt;
	logic [VAL_W-1:0]          popped_q;
	logic [FILL_W-1:0]         fill_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			// Stored values are ascending, so gt is a run of ones from the head.
			assign gt[i] = (count_q > CNT_W'(i)) && (value > ent_q[i]);

			always_ff @(posedge clk) begin
				if (ctl.pop) begin
					if (i < DEPTH - 1) begin
						ent_q[i] <= ent_q[(i + 1) % DEPTH];
					end
				end else if (ctl.insert && !gt[i]) begin
					if (i == 0) begin
						ent_q[i] <= value;
					end else if (gt[(i + DEPTH - 1) % DEPTH]) begin
						ent_q[i] <= value;
					end else begin
						ent_q[i] <= ent_q[(i + DEPTH - 1) % DEPTH];
					end
				end
			end
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		if (ctl.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	assign count_ext = {{FILL_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			popped_q <= ctl.pop ? ent_q[0] : '0;
			fill_q   <= count_ext[FILL_W-1:0];
		end
	end

	assign popped_value = popped_q;
	assign fill_level   = fill_q;

endmodule

// ----- rtl/sbpq_ctrl.sv -----
// Handshake controller: decodes requests and holds the result valid.
module sbpq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sbpq_pkg::cmd_t                   command,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [sbpq_pkg::STAT_W-1:0]      status,
	input  sbpq_pkg::dp_stat_t               stat,
	output sbpq_pkg::dp_ctl_t                ctl
);
	import sbpq_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	state_t            state_q;
	stat_t             status_q;
	stat_t             status_nxt;
	logic              take;

	// Accept while nothing is held or the held result leaves this cycle.
	assign in_ready = (state_q == ST_IDLE) || out_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		ctl        = '0;
		status_nxt = STAT_OK;
		ctl.capture = take;
		unique case (command)
			CMD_POP: begin
				if (stat.empty) begin
					status_nxt = STAT_EMPTY;
				end else begin
					ctl.pop = take;
				end
			end
			CMD_INSERT: begin
				if (stat.full) begin
					status_nxt = STAT_FULL;
				end else begin
					ctl.insert = take;
				end
			end
			default: begin
				status_nxt = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q  <= ST_HOLD;
						status_q <= status_nxt;
					end
				end
				ST_HOLD: begin
					if (take) begin
						status_q <= status_nxt;
					end else if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = (state_q == ST_HOLD);
	assign status    = status_q;

endmodule

// ----- rtl/sorted_byte_priority_queue_core.sv -----
// Top level of the sorted byte priority queue.
// Priority queue of up to DEPTH bytes kept in ascending order in a chain of
// registers. Send a request on the s_axis side: tuser selects the operation
// (0 insert tdata, 1 pop the smallest value) and tdata carries the byte to
// insert. Every request returns exactly one result on the m_axis side with the
// popped byte (zero unless a pop succeeded), a status in tuser (0 ok, 1 pop on
// an empty queue, 2 insert dropped because the queue is full) and the fill
// level after the request. An insert goes in front of the first stored value
// that is not smaller, so among equal values the newest pops first. Every
// cell of the chain compares the new byte against its own entry in parallel
// and shifts in the same edge. One result register sits on the output; a new
// request is taken when that register is empty or when its result leaves in the
// same cycle, so with m_axis_tready held high the queue sustains one request per
// cycle, and a stalled result stalls the input. The result is registered and
// valid in the cycle after its request is taken. Stored entries need no
// clearing after reset; only the fill count and controller state are reset.
module sorted_byte_priority_queue_core #(
	parameter int DEPTH = sbpq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] value
	input  logic        s_axis_tuser,   // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] popped_value, [12:8] fill_level, rest zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import sbpq_pkg::*;

	dp_ctl_t              ctl;
	dp_stat_t             stat;
	logic [VAL_W-1:0]     popped_value;
	logic [FILL_W-1:0]    fill_level;
	logic [STAT_W-1:0]    status;

	// Controller: handshakes, opcode decode, status code.
	sbpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.command   (cmd_t'(s_axis_tuser)),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.stat      (stat),
		.ctl       (ctl)
	);

	// Datapath: compare-and-shift chain, fill count, result registers.
	sbpq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.value        (s_axis_tdata),
		.stat         (stat),
		.popped_value (popped_value),
		.fill_level   (fill_level)
	);

	// Pack the result; pad the upper bits with zeros.
	assign m_axis_tdata = {3'b000, fill_level, popped_value};
	assign m_axis_tuser = status;

endmodule
